// ===== src/hbsd_pkg.sv =====
package hbsd_pkg;

  localparam int SYMBOLS_DEF = 256;
  localparam int SYM_W = 8;
  localparam int DEP_W = 8;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_COPY = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_JOIN = 4'b1000
  } bld_state_t;

endpackage

// ===== src/huffman_bit_serial_decoder_top.sv =====
// Decode request: one code bit per cycle while not busy; the symbol appears on out_ in the
// cycle after the bit that reaches a leaf is accepted. A load request stores its leaf while
// the list has room. The last leaf starts the tree rebuild, busy while it copies the leaves,
// then scans the list per depth level and joins pairs, all paced by the list memory's read port.
// Reset: no table is loaded and decode requests give no result until one is built.
// The receiver cannot stall; results are never held back.
module huffman_bit_serial_decoder_top #(
  parameter int SYMBOLS = hbsd_pkg::SYMBOLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_func,
  input  logic [hbsd_pkg::SYM_W-1:0] in_leaf_symbol,
  input  logic [hbsd_pkg::DEP_W-1:0] in_leaf_depth,
  input  logic                       in_leaf_last,
  input  logic                       in_code_bit,
  output logic                       out_valid,
  output logic [hbsd_pkg::SYM_W-1:0] out_decoded_symbol
);
  import hbsd_pkg::*;

  localparam int NODE_CNT = 2 * SYMBOLS - 1;
  localparam int NODE_W = $clog2(NODE_CNT);

  typedef struct packed {
    logic              leaf;
    logic [SYM_W-1:0]  sym;
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
  } node_ent_t;

  localparam int NODE_DW = $bits(node_ent_t);

  logic               accept;
  logic               ld_valid;
  logic               dec_valid;
  logic               bld_busy;
  logic               node_we;
  logic [NODE_W-1:0]  node_wa;
  logic [NODE_DW-1:0] node_wd;
  logic               bld_done;
  logic               bld_root_leaf;
  logic [SYM_W-1:0]   bld_root_sym;
  logic [NODE_W-1:0]  bld_root_left;
  logic [NODE_W-1:0]  bld_root_right;
  logic [NODE_DW-1:0] q_left;
  logic [NODE_DW-1:0] q_right;

  logic              ready_r, ready_nxt;
  logic              root_leaf_r, root_leaf_nxt;
  logic [SYM_W-1:0]  root_sym_r, root_sym_nxt;
  logic [NODE_W-1:0] root_left_r, root_left_nxt;
  logic [NODE_W-1:0] root_right_r, root_right_nxt;
  logic [NODE_W-1:0] wl_r, wl_nxt;
  logic [NODE_W-1:0] wr_r, wr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  out_sym_r, out_sym_nxt;

  assign busy = bld_busy;
  assign accept = start && !bld_busy;
  assign ld_valid = accept && (in_func == FUNC_LOAD);
  assign dec_valid = accept && (in_func == FUNC_DECODE) && ready_r;

  hbsd_build #(
    .SYMBOLS(SYMBOLS)
  ) u_build (
    .clk(clk),
    .rst_n(rst_n),
    .ld_valid(ld_valid),
    .ld_sym(in_leaf_symbol),
    .ld_dep(in_leaf_depth),
    .ld_last(in_leaf_last),
    .busy(bld_busy),
    .node_we(node_we),
    .node_wa(node_wa),
    .node_wd(node_wd),
    .done(bld_done),
    .root_leaf(bld_root_leaf),
    .root_sym(bld_root_sym),
    .root_left(bld_root_left),
    .root_right(bld_root_right)
  );

  // Once a table is built, the two read ports hold both children of the current walk node.
  hbsd_node_mem #(
    .DEPTH(NODE_CNT),
    .DW(NODE_DW),
    .AW(NODE_W)
  ) u_nodes (
    .clk(clk),
    .we(node_we),
    .wa(node_wa),
    .wd(node_wd),
    .ra_a(wl_nxt),
    .rd_a(q_left),
    .ra_b(wr_nxt),
    .rd_b(q_right)
  );

  always_comb begin
    node_ent_t child;
    child = in_code_bit ? q_right : q_left;

    ready_nxt = ready_r;
    root_leaf_nxt = root_leaf_r;
    root_sym_nxt = root_sym_r;
    root_left_nxt = root_left_r;
    root_right_nxt = root_right_r;
    wl_nxt = wl_r;
    wr_nxt = wr_r;
    out_valid_nxt = 1'b0;
    out_sym_nxt = out_sym_r;

    priority if (bld_done) begin
      ready_nxt = 1'b1;
      root_leaf_nxt = bld_root_leaf;
      root_sym_nxt = bld_root_sym;
      root_left_nxt = bld_root_left;
      root_right_nxt = bld_root_right;
      wl_nxt = bld_root_left;
      wr_nxt = bld_root_right;
    end else if (dec_valid) begin
      if (root_leaf_r) begin
        out_valid_nxt = 1'b1;
        out_sym_nxt = root_sym_r;
      end else if (child.leaf) begin
        out_valid_nxt = 1'b1;
        out_sym_nxt = child.sym;
        wl_nxt = root_left_r;
        wr_nxt = root_right_r;
      end else begin
        wl_nxt = child.left;
        wr_nxt = child.right;
      end
    end else begin
      wl_nxt = wl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ready_r <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_leaf_r <= root_leaf_nxt;
    root_sym_r <= root_sym_nxt;
    root_left_r <= root_left_nxt;
    root_right_r <= root_right_nxt;
    wl_r <= wl_nxt;
    wr_r <= wr_nxt;
    out_sym_r <= out_sym_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_decoded_symbol = out_sym_r;

  a_out_follows_decode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_func == FUNC_DECODE && ready_r))
    else $error("Result without a decode request.");

  a_out_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ready_r)
    else $error("Result while no table is loaded.");

  a_done_ends_build: assert property (@(posedge clk) disable iff (!rst_n)
    bld_done |=> !busy && ready_r)
    else $error("Rebuild finished but the decoder did not become ready.");

  a_node_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    node_we |-> busy)
    else $error("Node memory written outside a rebuild.");

endmodule

// ===== src/hbsd_list_mem.sv =====
module hbsd_list_mem #(
  parameter int DEPTH = hbsd_pkg::SYMBOLS_DEF,
  parameter int DW = 34,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic [AW-1:0] ra,
  output logic [DW-1:0] rd
);
  import hbsd_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  // A read of the entry being written returns the new data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (we && wa == ra) begin
      rd <= wd;
    end else begin
      rd <= mem[ra];
    end
  end

endmodule

// ===== src/hbsd_node_mem.sv =====
module hbsd_node_mem #(
  parameter int DEPTH = 2 * hbsd_pkg::SYMBOLS_DEF - 1,
  parameter int DW = 27,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic [AW-1:0] ra_a,
  output logic [DW-1:0] rd_a,
  input  logic [AW-1:0] ra_b,
  output logic [DW-1:0] rd_b
);
  import hbsd_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

endmodule

// ===== src/hbsd_build.sv =====
module hbsd_build #(
  parameter int SYMBOLS = hbsd_pkg::SYMBOLS_DEF,
  localparam int ADDR_W = $clog2(SYMBOLS),
  localparam int FILL_W = $clog2(SYMBOLS + 1),
  localparam int NODE_W = $clog2(2 * SYMBOLS - 1),
  localparam int NODE_DW = 1 + hbsd_pkg::SYM_W + 2 * NODE_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ld_valid,
  input  logic [hbsd_pkg::SYM_W-1:0] ld_sym,
  input  logic [hbsd_pkg::DEP_W-1:0] ld_dep,
  input  logic                       ld_last,
  output logic                       busy,
  output logic                       node_we,
  output logic [NODE_W-1:0]          node_wa,
  output logic [NODE_DW-1:0]         node_wd,
  output logic                       done,
  output logic                       root_leaf,
  output logic [hbsd_pkg::SYM_W-1:0] root_sym,
  output logic [NODE_W-1:0]          root_left,
  output logic [NODE_W-1:0]          root_right
);
  import hbsd_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [DEP_W-1:0]  dep;
    logic [NODE_W-1:0] node;
    logic [FILL_W-1:0] link;
  } list_ent_t;

  typedef struct packed {
    logic              leaf;
    logic [SYM_W-1:0]  sym;
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
  } node_ent_t;

  localparam int LIST_DW = $bits(list_ent_t);

  bld_state_t        state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] len_r, len_nxt;
  logic [DEP_W-1:0]  max_dep_r, max_dep_nxt;
  logic [DEP_W-1:0]  cur_r, cur_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] jpos_r, jpos_nxt;
  logic [NODE_W-1:0] jnode_r, jnode_nxt;
  logic [NODE_W-1:0] used_r, used_nxt;

  logic               list_we;
  logic [ADDR_W-1:0]  list_wa;
  logic [LIST_DW-1:0] list_wd;
  logic [ADDR_W-1:0]  list_ra;
  logic [LIST_DW-1:0] list_rd;

  hbsd_list_mem #(
    .DEPTH(SYMBOLS),
    .DW(LIST_DW),
    .AW(ADDR_W)
  ) u_list (
    .clk(clk),
    .we(list_we),
    .wa(list_wa),
    .wd(list_wd),
    .ra(list_ra),
    .rd(list_rd)
  );

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    list_ent_t rd_ent;
    list_ent_t wr_ent;
    node_ent_t nd_ent;
    logic      tail;
    logic [DEP_W-1:0] dep_max;
    rd_ent = list_rd;
    wr_ent = rd_ent;
    nd_ent = '0;
    tail = (rd_ent.link == fill_r);
    dep_max = (fill_r == '0 || ld_dep > max_dep_r) ? ld_dep : max_dep_r;

    state_nxt = state_r;
    fill_nxt = fill_r;
    len_nxt = len_r;
    max_dep_nxt = max_dep_r;
    cur_nxt = cur_r;
    pos_nxt = pos_r;
    jpos_nxt = jpos_r;
    jnode_nxt = jnode_r;
    used_nxt = used_r;
    list_we = 1'b0;
    list_wa = jpos_r;
    list_ra = pos_r;
    node_we = 1'b0;
    node_wa = used_r;
    done = 1'b0;
    root_leaf = 1'b0;
    root_sym = '0;
    root_left = '0;
    root_right = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (ld_valid) begin
          if (fill_r < FILL_W'(SYMBOLS)) begin
            list_we = 1'b1;
            list_wa = fill_r[ADDR_W-1:0];
            wr_ent.sym = ld_sym;
            wr_ent.dep = ld_dep;
            wr_ent.node = NODE_W'(fill_r);
            wr_ent.link = fill_r + FILL_W'(1);
            fill_nxt = fill_r + FILL_W'(1);
            max_dep_nxt = dep_max;
          end
          if (ld_last) begin
            state_nxt = ST_COPY;
            pos_nxt = '0;
            list_ra = '0;
            len_nxt = fill_nxt;
            cur_nxt = max_dep_nxt;
          end
        end
      end
      ST_COPY: begin
        node_we = 1'b1;
        node_wa = NODE_W'(pos_r);
        nd_ent.leaf = 1'b1;
        nd_ent.sym = rd_ent.sym;
        if ((FILL_W'(pos_r) + FILL_W'(1)) == len_r) begin
          if (len_r == FILL_W'(1)) begin
            done = 1'b1;
            root_leaf = 1'b1;
            root_sym = rd_ent.sym;
            fill_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SCAN;
            pos_nxt = '0;
            list_ra = '0;
            used_nxt = NODE_W'(len_r);
          end
        end else begin
          pos_nxt = pos_r + ADDR_W'(1);
          list_ra = pos_nxt;
        end
      end
      ST_SCAN: begin
        if (rd_ent.dep == cur_r && !tail) begin
          jpos_nxt = pos_r;
          jnode_nxt = rd_ent.node;
          list_ra = rd_ent.link[ADDR_W-1:0];
          state_nxt = ST_JOIN;
        end else if (tail) begin
          if (rd_ent.dep == cur_r) begin
            // The last node in the list has no partner and moves up in place.
            list_we = 1'b1;
            list_wa = pos_r;
            wr_ent.dep = cur_r - DEP_W'(1);
          end
          cur_nxt = cur_r - DEP_W'(1);
          pos_nxt = '0;
          list_ra = '0;
        end else begin
          pos_nxt = rd_ent.link[ADDR_W-1:0];
          list_ra = pos_nxt;
        end
      end
      ST_JOIN: begin
        node_we = 1'b1;
        node_wa = used_r;
        nd_ent.left = jnode_r;
        nd_ent.right = rd_ent.node;
        list_we = 1'b1;
        list_wa = jpos_r;
        wr_ent.dep = cur_r - DEP_W'(1);
        wr_ent.node = used_r;
        used_nxt = used_r + NODE_W'(1);
        len_nxt = len_r - FILL_W'(1);
        if (len_r == FILL_W'(2)) begin
          done = 1'b1;
          root_left = jnode_r;
          root_right = rd_ent.node;
          fill_nxt = '0;
          state_nxt = ST_IDLE;
        end else if (tail) begin
          cur_nxt = cur_r - DEP_W'(1);
          pos_nxt = '0;
          list_ra = '0;
          state_nxt = ST_SCAN;
        end else begin
          pos_nxt = rd_ent.link[ADDR_W-1:0];
          list_ra = pos_nxt;
          state_nxt = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    list_wd = wr_ent;
    node_wd = nd_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    max_dep_r <= max_dep_nxt;
    cur_r <= cur_nxt;
    pos_r <= pos_nxt;
    jpos_r <= jpos_nxt;
    jnode_r <= jnode_nxt;
    used_r <= used_nxt;
  end

endmodule
